// File: src/reverse_chunk_stereo_effect_top_macros.svh
// ----------------------------------------------------------------------------
// reverse chunk stereo effect - assertion macros
// Shorthand for the clocked implications used by the port checker.
// ----------------------------------------------------------------------------
`ifndef REVERSE_CHUNK_STEREO_EFFECT_TOP_MACROS_SVH
`define REVERSE_CHUNK_STEREO_EFFECT_TOP_MACROS_SVH

// antecedent and consequent in the same cycle
`define RCSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent starts in the cycle after the antecedent
`define RCSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rcse_pkg.sv
// ----------------------------------------------------------------------------
// rcse_pkg
// Shared widths, register indexes, reset values, types and helper functions.
// ----------------------------------------------------------------------------
package rcse_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int STORE_DEPTH = 262144;  // power of two
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int PAIR_W      = 2 * SAMPLE_BITS;
  localparam int TDATA_W     = ((PAIR_W + 7) / 8) * 8;

  localparam int POS_W     = 18;
  localparam int FADE_W    = 17;
  localparam int REC_W     = 32;
  localparam int GAIN_W    = 24;
  localparam int GAIN_FRAC = 22;
  localparam int W_W       = REC_W + 1;         // weight, one integer bit
  localparam int GD_W      = GAIN_W + 1;
  localparam int DIST_W    = POS_W + 1;
  localparam int MUL_W     = DIST_W + REC_W;
  localparam int CMP_W     = (ADDR_W > POS_W) ? ADDR_W : POS_W;

  localparam int WET_PROD_W = SAMPLE_BITS + GAIN_W + 1;
  localparam int DRY_PROD_W = SAMPLE_BITS + GD_W + 1;
  localparam int ACC_W      = DRY_PROD_W + 1;
  localparam int RND_W      = ACC_W - GAIN_FRAC;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [W_W-1:0]   W_ONE      = {1'b1, {REC_W{1'b0}}};
  localparam logic [GD_W-1:0]  GAIN_ONE   = GD_W'(1) << GAIN_FRAC;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (GAIN_FRAC - 1);

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [POS_W-1:0]  LEN_RESET  = POS_W'(24000);
  localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(1200);
  localparam logic [REC_W-1:0]  REC_RESET  = REC_W'(3579139);
  localparam logic [GAIN_W-1:0] WET_RESET  = GAIN_W'(4194304);
  localparam logic [GAIN_W-1:0] DRY_RESET  = '0;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_CHUNK_LENGTH    = 3'd0,
    REG_FADE_LENGTH     = 3'd1,
    REG_FADE_RECIPROCAL = 3'd2,
    REG_WET_GAIN        = 3'd3,
    REG_DRY_GAIN        = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_MID,
    ST_GAIN,
    ST_PROD,
    ST_SUM
  } state_t;

  typedef struct packed {
    logic [POS_W-1:0]  len;
    logic [FADE_W-1:0] fade;
    logic [REC_W-1:0]  rec;
    logic [GAIN_W-1:0] wet;
    logic [GAIN_W-1:0] dry;
  } cfg_t;

  // one strobe per datapath step
  typedef struct packed {
    logic w_edge;
    logic w_mid;
    logic gains;
    logic prod;
  } step_t;

  function automatic logic [W_W-1:0] clamp_one(input logic [MUL_W-1:0] v);
    logic [W_W-1:0] r;
    if (v > MUL_W'(W_ONE)) r = W_ONE;
    else r = v[W_W-1:0];
    return r;
  endfunction

  // positions map onto the store modulo its depth
  function automatic logic [ADDR_W-1:0] to_addr(input logic [POS_W-1:0] v);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(v);
    return a;
  endfunction

endpackage

// File: src/rcse_ram.sv
// ----------------------------------------------------------------------------
// rcse_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rcse_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/rcse_weight.sv
// ----------------------------------------------------------------------------
// rcse_weight
// Chunk weight and gain unit: edge ramps and mid-chunk dip on one shared
// multiplier, then wet and dry gains for the mixers.
// ----------------------------------------------------------------------------
module rcse_weight
  import rcse_pkg::*;
(
  input  logic              clk,
  input  step_t             step,
  input  cfg_t              cfg,
  input  logic [POS_W-1:0]  pos,
  input  logic [POS_W-1:0]  dist_end,
  output logic [GAIN_W-1:0] wet_w,
  output logic [GD_W-1:0]   dry_w
);

  logic [W_W-1:0]           weight;
  logic [DIST_W-1:0]        mid_dist;
  logic                     mid_near;
  logic                     near_end;
  logic                     near_start;
  logic [DIST_W-1:0]        pos2;
  logic [DIST_W-1:0]        len_x;
  logic [DIST_W-1:0]        dist_now;
  logic [DIST_W-1:0]        mul_a;
  logic [MUL_W-1:0]         prod;
  logic [GAIN_W+W_W-1:0]    wet_prod;

  always_comb begin
    near_end   = dist_end < POS_W'(cfg.fade);
    near_start = (DIST_W'(dist_end) + DIST_W'(cfg.fade)) > DIST_W'(cfg.len);
    pos2       = {pos, 1'b0};
    len_x      = DIST_W'(cfg.len);
    // twice the distance from mid-chunk
    dist_now   = (len_x >= pos2) ? (len_x - pos2) : (pos2 - len_x);
    if (step.w_mid) mul_a = mid_dist;
    else if (near_end) mul_a = DIST_W'(dist_end);
    else mul_a = DIST_W'(pos);
    prod     = MUL_W'(mul_a) * MUL_W'(cfg.rec);
    wet_prod = (GAIN_W+W_W)'(cfg.wet) * (GAIN_W+W_W)'(weight);
  end

  always_ff @(posedge clk) begin
    if (step.w_edge) begin
      weight   <= (near_end || near_start) ? clamp_one(prod) : W_ONE;
      mid_dist <= dist_now;
      mid_near <= dist_now < DIST_W'({cfg.fade, 1'b0});
    end
    if (step.w_mid) begin
      // the dip only replaces a full weight
      if ((weight == W_ONE) && mid_near) begin
        weight <= clamp_one({1'b0, prod[MUL_W-1:1]});
      end
    end
    if (step.gains) begin
      wet_w <= wet_prod[REC_W +: GAIN_W];
      dry_w <= GD_W'(cfg.dry) + GAIN_ONE - GD_W'(weight >> (REC_W - GAIN_FRAC));
    end
  end

endmodule

// File: src/rcse_mix.sv
// ----------------------------------------------------------------------------
// rcse_mix
// One channel of the output mix: registered products, then sum, round half
// up and saturate.
// ----------------------------------------------------------------------------
module rcse_mix
  import rcse_pkg::*;
(
  input  logic                          clk,
  input  logic                          ld_prod,
  input  logic signed [SAMPLE_BITS-1:0] stored,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [GAIN_W-1:0]             wet_w,
  input  logic [GD_W-1:0]               dry_w,
  output logic [SAMPLE_BITS-1:0]        result
);

  logic signed [WET_PROD_W-1:0] wet_part;
  logic signed [DRY_PROD_W-1:0] dry_part;
  logic [ACC_W-1:0]             acc;
  logic [RND_W-1:0]             rounded;
  logic                         in_range;

  always_ff @(posedge clk) begin
    if (ld_prod) begin
      wet_part <= stored * $signed({1'b0, wet_w});
      dry_part <= sample * $signed({1'b0, dry_w});
    end
  end

  always_comb begin
    acc = {{(ACC_W-WET_PROD_W){wet_part[WET_PROD_W-1]}}, wet_part}
        + {{(ACC_W-DRY_PROD_W){dry_part[DRY_PROD_W-1]}}, dry_part}
        + ROUND_HALF;
    // arithmetic shift by the gain fraction is a floor
    rounded  = acc[ACC_W-1:GAIN_FRAC];
    in_range = (&rounded[RND_W-1:SAMPLE_BITS-1]) || !(|rounded[RND_W-1:SAMPLE_BITS-1]);
    if (in_range) result = rounded[SAMPLE_BITS-1:0];
    else if (rounded[RND_W-1]) result = SAMPLE_MIN;
    else result = SAMPLE_MAX;
  end

endmodule

// File: src/reverse_chunk_stereo_effect_top.sv
// ----------------------------------------------------------------------------
// reverse_chunk_stereo_effect_top
// Stereo reverse-chunk effect: each pair is stored at the chunk position and
// the pair mirrored about the chunk end is mixed back, weighted by edge fades
// and a mid-chunk dip.
// ----------------------------------------------------------------------------
// channel   dir   handshake          payload
// s_*       in    s_tvalid/s_tready  s_tdata: left_in, right_in
// m_*       out   m_tvalid/m_tready  m_tdata: left_out, right_out
// cfg_*     in    cfg_we             cfg_addr register index, cfg_data value
//
// per item, in order: the store read at acceptance, then edge weight and
// store write, mid-chunk weight (second pass of the shared weight
// multiplier), gains, channel products, and the sum into the output register.
// reset is synchronous; the store is not swept, a fill count of the written
// prefix makes unwritten entries read as zero.
// a result not taken holds the sum step; input is taken again once the
// result sits in the output register.
// ----------------------------------------------------------------------------
module reverse_chunk_stereo_effect_top
  import rcse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,   // left_in, right_in
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_W-1:0]    m_tdata,   // left_out, right_out
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t                  state;
  state_t                  state_next;
  cfg_t                    cfg;
  step_t                   step;
  logic [POS_W-1:0]        chunk_position;
  logic [POS_W-1:0]        fill;
  logic [POS_W-1:0]        pos_r;
  logic [POS_W-1:0]        p_r;
  logic [SAMPLE_BITS-1:0]  left_r;
  logic [SAMPLE_BITS-1:0]  right_r;
  logic [SAMPLE_BITS-1:0]  stored_l;
  logic [SAMPLE_BITS-1:0]  stored_r;
  logic                    rd_valid;
  logic [SAMPLE_BITS-1:0]  left_out;
  logic [SAMPLE_BITS-1:0]  right_out;
  logic [SAMPLE_BITS-1:0]  mix_l;
  logic [SAMPLE_BITS-1:0]  mix_r;
  logic [GAIN_W-1:0]       wet_w;
  logic [GD_W-1:0]         dry_w;
  logic [PAIR_W-1:0]       rd_data;
  logic [POS_W-1:0]        pos_now;
  logic [POS_W-1:0]        p_now;
  logic [POS_W-1:0]        pos_inc;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    rd_hit;
  logic                    accept;
  logic                    out_free;
  logic                    out_load;
  logic                    wr_en;

  always_comb begin
    pos_now = (chunk_position >= cfg.len) ? '0 : chunk_position;
    p_now   = cfg.len - pos_now;
    rd_addr = to_addr(p_now);
    // only the prefix below the fill count has ever been written
    rd_hit  = CMP_W'(rd_addr) < CMP_W'(fill);
    pos_inc = pos_r + POS_W'(1);
  end

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_EDGE;
      ST_EDGE: state_next = ST_MID;
      ST_MID:  state_next = ST_GAIN;
      ST_GAIN: state_next = ST_PROD;
      ST_PROD: state_next = ST_SUM;
      ST_SUM:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    step     = '0;
    s_tready = 1'b0;
    wr_en    = 1'b0;
    out_load = 1'b0;
    case (state)
      // no item is taken while reset is held
      ST_IDLE: s_tready = !rst;
      ST_EDGE: begin
        step.w_edge = 1'b1;
        wr_en       = 1'b1;
      end
      ST_MID:  step.w_mid = 1'b1;
      ST_GAIN: step.gains = 1'b1;
      ST_PROD: step.prod  = 1'b1;
      ST_SUM:  out_load   = out_free;
      default: s_tready   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      chunk_position <= '0;
      fill           <= '0;
      m_tvalid       <= 1'b0;
      cfg.len        <= LEN_RESET;
      cfg.fade       <= FADE_RESET;
      cfg.rec        <= REC_RESET;
      cfg.wet        <= WET_RESET;
      cfg.dry        <= DRY_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_CHUNK_LENGTH:    cfg.len  <= cfg_data[POS_W-1:0];
          REG_FADE_LENGTH:     cfg.fade <= cfg_data[FADE_W-1:0];
          REG_FADE_RECIPROCAL: cfg.rec  <= cfg_data[REC_W-1:0];
          REG_WET_GAIN:        cfg.wet  <= cfg_data[GAIN_W-1:0];
          REG_DRY_GAIN:        cfg.dry  <= cfg_data[GAIN_W-1:0];
          default:             cfg      <= cfg;
        endcase
      end
      if (accept) begin
        chunk_position <= pos_now + POS_W'(1);
      end
      if (wr_en && (pos_inc > fill)) begin
        fill <= pos_inc;
      end
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r    <= pos_now;
      p_r      <= p_now;
      left_r   <= s_tdata[SAMPLE_BITS-1:0];
      right_r  <= s_tdata[PAIR_W-1:SAMPLE_BITS];
      rd_valid <= rd_hit;
    end
    if (wr_en) begin
      stored_l <= rd_valid ? rd_data[SAMPLE_BITS-1:0] : '0;
      stored_r <= rd_valid ? rd_data[PAIR_W-1:SAMPLE_BITS] : '0;
    end
    if (out_load) begin
      left_out  <= mix_l;
      right_out <= mix_r;
    end
  end

  assign m_tdata = TDATA_W'({right_out, left_out});

  rcse_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (to_addr(pos_r)),
    .wr_data ({right_r, left_r}),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rcse_weight u_weight (
    .clk      (clk),
    .step     (step),
    .cfg      (cfg),
    .pos      (pos_r),
    .dist_end (p_r),
    .wet_w    (wet_w),
    .dry_w    (dry_w)
  );

  rcse_mix u_mix_l (
    .clk     (clk),
    .ld_prod (step.prod),
    .stored  ($signed(stored_l)),
    .sample  ($signed(left_r)),
    .wet_w   (wet_w),
    .dry_w   (dry_w),
    .result  (mix_l)
  );

  rcse_mix u_mix_r (
    .clk     (clk),
    .ld_prod (step.prod),
    .stored  ($signed(stored_r)),
    .sample  ($signed(right_r)),
    .wet_w   (wet_w),
    .dry_w   (dry_w),
    .result  (mix_r)
  );

endmodule

// File: src/rcse_checker.sv
// ----------------------------------------------------------------------------
// rcse_checker
// Port-level checks on the stream channels of the reverse chunk effect.
// ----------------------------------------------------------------------------
`include "reverse_chunk_stereo_effect_top_macros.svh"

module rcse_checker
  import rcse_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  `RCSE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // an accepted item keeps the input closed through its edge, mid, gain, product and sum steps
  `RCSE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready, "input reopened before the item finished")

  // a fresh result only comes out of a busy cycle
  `RCSE_ASSERT_NOW(a_result_from_work, $rose(m_tvalid), $past(!s_tready), "result appeared without work")

  // input stays closed while a newly taken item works and an earlier result is still stalled
  `RCSE_ASSERT_NEXT(a_sum_waits, !s_tready && m_tvalid && !m_tready && $past(s_tready), !s_tready, "input reopened before a result left")

endmodule

bind reverse_chunk_stereo_effect_top rcse_checker u_checker (.*);

// File: dv/tb_reverse_chunk_stereo_effect_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reverse_chunk_stereo_effect_top
// Streams stereo pairs through the reverse-chunk effect under several register
// settings and random idling on both sides. Every output pair is checked
// against an in-bench model of the chunk store, fade weights and mix.
// ----------------------------------------------------------------------------
module tb_reverse_chunk_stereo_effect_top;
  import rcse_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_PHASES  = 12;
  localparam int RANDOM_ITEMS   = 166;
  localparam int HOLD_CYCLES    = 300;

  localparam longint unsigned WEIGHT_ONE = 64'h1_0000_0000;
  localparam longint unsigned POS_MAX    = (64'd1 << POS_W) - 1;
  localparam longint unsigned FADE_MAX   = (64'd1 << FADE_W) - 1;
  localparam longint unsigned GAIN_MAX   = (64'd1 << GAIN_W) - 1;
  localparam longint unsigned GAIN_TWO   = 64'd1 << (GAIN_FRAC + 1);
  localparam longint SAT_HI     = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO     = -SAT_HI - 1;
  localparam longint ROUND_BIAS = longint'(1) <<< (GAIN_FRAC - 1);

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] right;
    logic [SAMPLE_BITS-1:0] left;
  } sample_pair_t;

  localparam logic [SAMPLE_BITS-1:0] EDGE_VALUES [6] = '{
    SAMPLE_MAX, SAMPLE_MIN, {SAMPLE_BITS{1'b0}}, {SAMPLE_BITS{1'b1}},
    {(SAMPLE_BITS/2){2'b01}}, {(SAMPLE_BITS/2){2'b10}}
  };

  class reverse_mix_board;
    bit [SAMPLE_BITS-1:0] held_left  [STORE_DEPTH];
    bit [SAMPLE_BITS-1:0] held_right [STORE_DEPTH];
    longint unsigned position;
    longint unsigned chunk_len, fade_len, fade_rec, wet, dry;
    sample_pair_t expected_pairs[$];
    int errors;

    function new();
      position  = 0;
      chunk_len = longint'(LEN_RESET);
      fade_len  = longint'(FADE_RESET);
      fade_rec  = longint'(REC_RESET);
      wet       = longint'(WET_RESET);
      dry       = longint'(DRY_RESET);
      errors    = 0;
    endfunction

    function void write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_CHUNK_LENGTH:    chunk_len = longint'(value[POS_W-1:0]);
        REG_FADE_LENGTH:     fade_len  = longint'(value[FADE_W-1:0]);
        REG_FADE_RECIPROCAL: fade_rec  = longint'(value[REC_W-1:0]);
        REG_WET_GAIN:        wet       = longint'(value[GAIN_W-1:0]);
        REG_DRY_GAIN:        dry       = longint'(value[GAIN_W-1:0]);
        default: ;
      endcase
    endfunction

    function logic [SAMPLE_BITS-1:0] blend(input longint stored, input longint direct,
                                           input longint unsigned gw,
                                           input longint unsigned gd);
      longint acc;
      acc = stored * longint'(gw) + direct * longint'(gd);
      acc = (acc + ROUND_BIAS) >>> GAIN_FRAC;
      if (acc > SAT_HI) acc = SAT_HI;
      else if (acc < SAT_LO) acc = SAT_LO;
      return acc[SAMPLE_BITS-1:0];
    endfunction

    // read the mirrored entry, then overwrite the current one
    function void note_input(input sample_pair_t x);
      longint unsigned pos, mirror, rd, wr, w, d, gw, gd;
      longint sl, sr;
      sample_pair_t y;
      if (position >= chunk_len) position = 0;
      pos    = position;
      mirror = chunk_len - pos;
      rd = mirror % longint'(STORE_DEPTH);
      wr = pos % longint'(STORE_DEPTH);
      sl = longint'($signed(held_left[rd]));
      sr = longint'($signed(held_right[rd]));
      held_left[wr]  = x.left;
      held_right[wr] = x.right;

      if (mirror < fade_len) w = mirror * fade_rec;
      else if (mirror + fade_len > chunk_len) w = pos * fade_rec;
      else w = WEIGHT_ONE;
      if (w > WEIGHT_ONE) w = WEIGHT_ONE;
      if (w == WEIGHT_ONE) begin
        d = (chunk_len >= 2 * pos) ? chunk_len - 2 * pos : 2 * pos - chunk_len;
        if (d < 2 * fade_len) begin
          w = (d * fade_rec) >> 1;
          if (w > WEIGHT_ONE) w = WEIGHT_ONE;
        end
      end

      gw = (wet * w) >> 32;
      gd = dry + (64'd1 << GAIN_FRAC) - (w >> 10);
      y.left  = blend(sl, longint'($signed(x.left)), gw, gd);
      y.right = blend(sr, longint'($signed(x.right)), gw, gd);
      expected_pairs.push_back(y);
      position = (pos + 1) & POS_MAX;
    endfunction

    function void check_output(input logic [TDATA_W-1:0] data);
      sample_pair_t got, want;
      got = sample_pair_t'(data[PAIR_W-1:0]);
      if (expected_pairs.size() == 0) begin
        $error("output item with nothing expected: %h", data);
        errors++;
        return;
      end
      want = expected_pairs.pop_front();
      if (got.left !== want.left) begin
        $error("left_out: expected %0d, got %0d", $signed(want.left), $signed(got.left));
        errors++;
      end
      if (got.right !== want.right) begin
        $error("right_out: expected %0d, got %0d", $signed(want.right), $signed(got.right));
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata = '0;    // left_in, right_in
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;         // left_out, right_out
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  reverse_mix_board mix_board = new();
  int send_idle = 20;
  int recv_idle = 56;
  int sent = 0;
  int quiet_cycles = 0;

  always #2 clk = ~clk;

  reverse_chunk_stereo_effect_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0: return EDGE_VALUES[$urandom_range(5)];
      1: return SAMPLE_BITS'($urandom_range(255));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic put_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    mix_board.write_reg(idx, value);
  endtask

  task automatic configure(input longint unsigned len, input longint unsigned fade,
                           input longint unsigned rec, input longint unsigned wet_g,
                           input longint unsigned dry_g);
    put_reg(REG_CHUNK_LENGTH, CFG_DATA_W'(len));
    put_reg(REG_FADE_LENGTH, CFG_DATA_W'(fade));
    put_reg(REG_FADE_RECIPROCAL, CFG_DATA_W'(rec));
    put_reg(REG_WET_GAIN, CFG_DATA_W'(wet_g));
    put_reg(REG_DRY_GAIN, CFG_DATA_W'(dry_g));
    cfg_we <= 1'b0;
  endtask

  // wait until every expected item is out and the datapath has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (mix_board.expected_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic feed_pairs(input int count, input bit from_table);
    sample_pair_t x;
    for (int i = 0; i < count; i++) begin
      if (from_table) begin
        x.left  = EDGE_VALUES[i % 6];
        x.right = EDGE_VALUES[(i + i / 6 + 1) % 6];
      end else begin
        x.left  = pick_sample();
        x.right = pick_sample();
      end
      while ($urandom_range(99) < send_idle) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= TDATA_W'(x);
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      mix_board.note_input(x);
      sent++;
      if (sent < 700) begin
        send_idle = 20;
        recv_idle = 56;
      end else if (sent < 1400) begin
        send_idle = 56;
        recv_idle = 20;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
    end
  endtask

  initial begin : result_sink
    int got;
    int hold_left;
    bit held_off;
    got = 0;
    hold_left = 0;
    held_off = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        mix_board.check_output(m_tdata);
        got++;
      end
      // one long back-pressure spell, started while the sender is offering
      if (!held_off && got >= 250 && s_tvalid) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    longint unsigned len, fade, rec, wet_g, dry_g;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: store still empty, weight starts at zero
    feed_pairs(6, 1'b1);
    // short chunk, gains of two, over-large reciprocal: saturation both ways
    settle();
    configure(4, 1, 64'hFFFF_FFFF, GAIN_TWO, GAIN_TWO);
    feed_pairs(8, 1'b1);
    // zero chunk length with a fade set
    settle();
    configure(0, 3, 64'd1431655765, GAIN_MAX, GAIN_MAX);
    feed_pairs(3, 1'b1);
    // no fade: full reversed signal, no dip
    settle();
    configure(3, 0, 0, GAIN_TWO, 0);
    feed_pairs(5, 1'b1);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      case (k)
        0: len = 1;
        1: len = POS_MAX;
        2: len = 0;
        default: len = ($urandom_range(3) == 0) ? $urandom_range(4000, 65)
                                                : $urandom_range(64, 2);
      endcase
      case ($urandom_range(7))
        0: fade = 0;
        1: fade = FADE_MAX;
        2: fade = $urandom_range(FADE_MAX);
        default: fade = $urandom_range((len / 2 < FADE_MAX) ? len / 2 : FADE_MAX);
      endcase
      if (fade == 0) rec = 0;
      else rec = WEIGHT_ONE / fade;
      if (rec > 64'hFFFF_FFFF) rec = 64'hFFFF_FFFF;
      case ($urandom_range(5))
        0: rec = $urandom;
        1: rec = 64'hFFFF_FFFF;
        default: ;
      endcase
      case ($urandom_range(5))
        0: wet_g = 0;
        1: wet_g = GAIN_TWO;
        2: wet_g = GAIN_MAX;
        default: wet_g = $urandom_range(GAIN_TWO);
      endcase
      case ($urandom_range(5))
        0: dry_g = 0;
        1: dry_g = GAIN_TWO;
        2: dry_g = GAIN_MAX;
        default: dry_g = $urandom_range(GAIN_TWO);
      endcase
      settle();
      configure(len, fade, rec, wet_g, dry_g);
      feed_pairs(RANDOM_ITEMS, 1'b0);
    end

    settle();
    if (mix_board.errors == 0 && mix_board.expected_pairs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
